// ----- hw/rtl/fpx_pkg.sv -----
package fpx_pkg;

    localparam int BUF_DEPTH  = 512;
    localparam int MAX_LENGTH = 255;

    localparam int ADDR_W    = $clog2(BUF_DEPTH);
    localparam int FILL_W    = $clog2(BUF_DEPTH + 1);
    localparam int LEN_W     = 16;
    localparam int POS_W     = 9;
    localparam int STAT_W    = 3;
    localparam int CFG_IDX_W = 8;

    // Fixed positions of the frame header in the buffer.
    localparam int POS_ID     = 2;
    localparam int POS_TYPE   = 3;
    localparam int POS_LEN_LO = 4;
    localparam int POS_LEN_HI = 5;

    localparam logic [7:0] TYPE_CK_MIN = 8'h20;
    localparam int LEN_OVERHEAD = 9;
    localparam int TAIL_BACK    = 3;

    // The checksum walk runs from POS_ID up to length + POS_LEN_HI.
    localparam int WALK_MAX = MAX_LENGTH + POS_LEN_HI;
    localparam int WALK_W   = $clog2(WALK_MAX + 2);

    localparam logic [CFG_IDX_W-1:0] CFG_HEAD_FIRST  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_HEAD_SECOND = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_END_FIRST   = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_END_SECOND  = CFG_IDX_W'(3);

    typedef enum logic [STAT_W-1:0] {
        ST_BUSY    = 3'd0,
        ST_CK_OK   = 3'd1,
        ST_LEN_OK  = 3'd2,
        ST_CK_BAD  = 3'd3,
        ST_LEN_BAD = 3'd4,
        ST_OVF     = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        RS_NONE,
        RS_ID,
        RS_TYPE,
        RS_LEN_LO,
        RS_LEN_HI,
        RS_TAIL,
        RS_WALK
    } t_rd_sel;

    typedef struct packed {
        logic    clr_write;
        logic    load_byte;
        logic    store;
        logic    fill_zero;
        logic    fill_clear;
        t_rd_sel rd_sel;
        logic    walk_start;
        logic    out_load;
        t_status out_status;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_last;
        logic hit_h1;
        logic hit_h2;
        logic hit_e1;
        logic hit_e2;
        logic buf_full;
        logic type_ck;
        logic walk_last;
        logic ck_ok;
        logic len_ok;
        logic out_free;
    } t_dp_stat;

endpackage

// ----- hw/rtl/fpx_ram.sv -----
module fpx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/fpx_dpath.sv -----
module fpx_dpath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  fpx_pkg::t_dp_cmd                i_cmd,
    output fpx_pkg::t_dp_stat               o_stat,
    input  logic [7:0]                      i_rx_byte,
    input  logic                            i_cfg_valid,
    input  logic [fpx_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [7:0]                      i_cfg_data,
    input  logic                            i_out_stall,
    output logic                            o_out_valid,
    output logic [fpx_pkg::STAT_W-1:0]      o_frame_status,
    output logic [7:0]                      o_frame_id,
    output logic [7:0]                      o_frame_type,
    output logic [fpx_pkg::LEN_W-1:0]       o_frame_length,
    output logic                            o_byte_stored,
    output logic [fpx_pkg::POS_W-1:0]       o_byte_position,
    output logic [7:0]                      o_byte_value
);
    import fpx_pkg::*;

    logic [7:0]        r_head_first, r_head_second, r_end_first, r_end_second;
    logic [7:0]        r_byte;
    logic [FILL_W-1:0] r_fill;
    logic [ADDR_W-1:0] r_clr_addr;
    logic              r_st_flag;
    logic [ADDR_W-1:0] r_st_pos;
    logic [7:0]        r_id, r_type, r_len_lo, r_len_hi, r_tail, r_acc;
    logic [WALK_W-1:0] r_waddr;
    t_rd_sel           r_cap_sel;
    logic              r_cap_mask;

    logic              r_out_valid;
    t_status           r_o_status;
    logic [7:0]        r_o_id, r_o_type, r_o_value;
    logic [LEN_W-1:0]  r_o_len;
    logic              r_o_stored;
    logic [POS_W-1:0]  r_o_pos;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [7:0]        ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [7:0]        ram_rdata;

    logic [FILL_W-1:0] tail_pos;
    logic [FILL_W-1:0] fill_less_ovh;
    logic [LEN_W-1:0]  header_len;
    logic [WALK_W-1:0] walk_lim;
    logic              walk_in_buf;
    logic              frame_result;

    assign header_len    = {r_len_hi, r_len_lo};
    assign tail_pos      = r_fill - FILL_W'(TAIL_BACK);
    assign fill_less_ovh = r_fill - FILL_W'(LEN_OVERHEAD);
    // An oversized header length walks only the header itself.
    assign walk_lim = (header_len > LEN_W'(MAX_LENGTH))
                      ? WALK_W'(POS_LEN_HI)
                      : WALK_W'(header_len) + WALK_W'(POS_LEN_HI);
    assign walk_in_buf = (int'(r_waddr) < BUF_DEPTH);

    assign ram_we    = i_cmd.clr_write | i_cmd.store;
    assign ram_waddr = i_cmd.clr_write ? r_clr_addr
                     : (i_cmd.fill_zero ? '0 : r_fill[ADDR_W-1:0]);
    assign ram_wdata = i_cmd.clr_write ? 8'h00 : r_byte;

    always_comb begin
        case (i_cmd.rd_sel)
            RS_ID:     ram_raddr = ADDR_W'(POS_ID);
            RS_TYPE:   ram_raddr = ADDR_W'(POS_TYPE);
            RS_LEN_LO: ram_raddr = ADDR_W'(POS_LEN_LO);
            RS_LEN_HI: ram_raddr = ADDR_W'(POS_LEN_HI);
            RS_TAIL:   ram_raddr = tail_pos[ADDR_W-1:0];
            RS_WALK:   ram_raddr = ADDR_W'(r_waddr);
            default:   ram_raddr = '0;
        endcase
    end

    fpx_ram #(
        .WIDTH (8),
        .DEPTH (BUF_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_first  <= '0;
            r_head_second <= '0;
            r_end_first   <= '0;
            r_end_second  <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_HEAD_FIRST:  r_head_first  <= i_cfg_data;
                CFG_HEAD_SECOND: r_head_second <= i_cfg_data;
                CFG_END_FIRST:   r_end_first   <= i_cfg_data;
                CFG_END_SECOND:  r_end_second  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill     <= '0;
            r_clr_addr <= '0;
            r_waddr    <= '0;
            r_cap_sel  <= RS_NONE;
            r_st_flag  <= 1'b0;
        end else begin
            if (i_cmd.clr_write) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_cmd.fill_clear) begin
                r_fill <= '0;
            end else if (i_cmd.store) begin
                r_fill <= i_cmd.fill_zero ? FILL_W'(1) : r_fill + 1'b1;
            end
            if (i_cmd.load_byte) begin
                r_st_flag <= 1'b0;
            end else if (i_cmd.store) begin
                r_st_flag <= 1'b1;
            end
            if (i_cmd.walk_start) begin
                r_waddr <= WALK_W'(POS_ID);
            end else if (i_cmd.rd_sel == RS_WALK) begin
                r_waddr <= r_waddr + 1'b1;
            end
            r_cap_sel <= i_cmd.rd_sel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_byte) begin
            r_byte <= i_rx_byte;
        end
        if (i_cmd.store) begin
            r_st_pos <= ram_waddr;
        end
        r_cap_mask <= walk_in_buf;
        if (i_cmd.walk_start) begin
            r_acc <= '0;
        end else if (r_cap_sel == RS_WALK) begin
            r_acc <= r_acc ^ (ram_rdata & {8{r_cap_mask}});
        end
        case (r_cap_sel)
            RS_ID:     r_id     <= ram_rdata;
            RS_TYPE:   r_type   <= ram_rdata;
            RS_LEN_LO: r_len_lo <= ram_rdata;
            RS_LEN_HI: r_len_hi <= ram_rdata;
            RS_TAIL:   r_tail   <= ram_rdata;
            default: ;
        endcase
    end

    assign frame_result = (i_cmd.out_status == ST_CK_OK)  || (i_cmd.out_status == ST_LEN_OK)
                       || (i_cmd.out_status == ST_CK_BAD) || (i_cmd.out_status == ST_LEN_BAD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_o_status <= i_cmd.out_status;
            r_o_id     <= frame_result ? r_id : 8'h00;
            r_o_type   <= frame_result ? r_type : 8'h00;
            r_o_len    <= frame_result ? header_len : '0;
            r_o_stored <= r_st_flag;
            r_o_pos    <= r_st_flag ? POS_W'(r_st_pos) : '0;
            r_o_value  <= r_st_flag ? r_byte : 8'h00;
        end
    end

    always_comb begin
        o_stat.clr_last  = (r_clr_addr == ADDR_W'(BUF_DEPTH - 1));
        o_stat.hit_h1    = (r_byte == r_head_first);
        o_stat.hit_h2    = (r_byte == r_head_second);
        o_stat.hit_e1    = (r_byte == r_end_first);
        o_stat.hit_e2    = (r_byte == r_end_second);
        o_stat.buf_full  = (r_fill == FILL_W'(BUF_DEPTH));
        o_stat.type_ck   = (r_type >= TYPE_CK_MIN);
        o_stat.walk_last = (r_waddr == walk_lim);
        o_stat.ck_ok     = (r_acc == r_tail);
        o_stat.len_ok    = (r_fill >= FILL_W'(LEN_OVERHEAD))
                        && (header_len == LEN_W'(fill_less_ovh));
        o_stat.out_free  = !r_out_valid || !i_out_stall;
    end

    assign o_out_valid     = r_out_valid;
    assign o_frame_status  = r_o_status;
    assign o_frame_id      = r_o_id;
    assign o_frame_type    = r_o_type;
    assign o_frame_length  = r_o_len;
    assign o_byte_stored   = r_o_stored;
    assign o_byte_position = r_o_pos;
    assign o_byte_value    = r_o_value;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(BUF_DEPTH))
        else $error("fill count beyond buffer depth");

    a_ovf_not_stored: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_o_status == ST_OVF) |-> !r_o_stored)
        else $error("overflow result claims a stored byte");

    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_waddr <= WALK_W'(WALK_MAX + 1))
        else $error("checksum walk ran past its limit");
`endif

endmodule

// ----- hw/rtl/fpx_ctrl.sv -----
module fpx_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  fpx_pkg::t_dp_stat  i_stat,
    output fpx_pkg::t_dp_cmd   o_cmd
);
    import fpx_pkg::*;

    typedef enum logic [3:0] {
        S_CLR,
        S_IDLE,
        S_DECODE,
        S_RD_ID,
        S_RD_TYPE,
        S_RD_LO,
        S_RD_HI,
        S_RD_TAIL,
        S_HDR_WAIT,
        S_DECIDE,
        S_WALK,
        S_WALK_WAIT,
        S_CK_RES,
        S_EMIT
    } t_state;

    typedef enum logic [1:0] {
        PH_HEAD1,
        PH_HEAD2,
        PH_DATA,
        PH_END2
    } t_phase;

    t_state  r_state;
    t_phase  r_phase;
    t_status r_status;

    logic    dec_store, dec_fill_zero, dec_fill_clear, dec_ovf, dec_end;
    t_phase  dec_phase;

    // Parse decision for the byte held in the datapath.
    always_comb begin
        dec_store      = 1'b0;
        dec_fill_zero  = 1'b0;
        dec_fill_clear = 1'b0;
        dec_ovf        = 1'b0;
        dec_end        = 1'b0;
        dec_phase      = r_phase;
        unique case (r_phase)
            PH_HEAD1: begin
                if (i_stat.hit_h1) begin
                    dec_store     = 1'b1;
                    dec_fill_zero = 1'b1;
                    dec_phase     = PH_HEAD2;
                end
            end
            PH_HEAD2: begin
                if (!i_stat.hit_h2) begin
                    dec_phase = PH_HEAD1;
                end else if (i_stat.buf_full) begin
                    dec_ovf        = 1'b1;
                    dec_fill_clear = 1'b1;
                    dec_phase      = PH_HEAD1;
                end else begin
                    dec_store = 1'b1;
                    dec_phase = PH_DATA;
                end
            end
            PH_DATA: begin
                if (i_stat.buf_full) begin
                    dec_ovf        = 1'b1;
                    dec_fill_clear = 1'b1;
                    dec_phase      = PH_HEAD1;
                end else begin
                    dec_store = 1'b1;
                    if (i_stat.hit_e1) begin
                        dec_phase = PH_END2;
                    end
                end
            end
            PH_END2: begin
                if (i_stat.buf_full) begin
                    dec_ovf        = 1'b1;
                    dec_fill_clear = 1'b1;
                    dec_phase      = PH_HEAD1;
                end else begin
                    dec_store = 1'b1;
                    if (i_stat.hit_e2) begin
                        dec_end   = 1'b1;
                        dec_phase = PH_HEAD1;
                    end else begin
                        dec_phase = PH_DATA;
                    end
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        o_cmd            = '0;
        o_cmd.rd_sel     = RS_NONE;
        o_cmd.out_status = r_status;
        unique case (r_state)
            S_CLR:    o_cmd.clr_write = 1'b1;
            S_IDLE:   o_cmd.load_byte = i_in_valid;
            S_DECODE: begin
                o_cmd.store      = dec_store;
                o_cmd.fill_zero  = dec_fill_zero;
                o_cmd.fill_clear = dec_fill_clear;
            end
            S_RD_ID:   o_cmd.rd_sel = RS_ID;
            S_RD_TYPE: o_cmd.rd_sel = RS_TYPE;
            S_RD_LO:   o_cmd.rd_sel = RS_LEN_LO;
            S_RD_HI:   o_cmd.rd_sel = RS_LEN_HI;
            S_RD_TAIL: o_cmd.rd_sel = RS_TAIL;
            S_DECIDE:  o_cmd.walk_start = i_stat.type_ck;
            S_WALK:    o_cmd.rd_sel = RS_WALK;
            S_EMIT:    o_cmd.out_load = i_stat.out_free;
            default: ;
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_phase  <= PH_HEAD1;
            r_status <= ST_BUSY;
        end else begin
            unique case (r_state)
                S_CLR: begin
                    if (i_stat.clr_last) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    r_phase  <= dec_phase;
                    r_status <= dec_ovf ? ST_OVF : ST_BUSY;
                    r_state  <= dec_end ? S_RD_ID : S_EMIT;
                end
                S_RD_ID:    r_state <= S_RD_TYPE;
                S_RD_TYPE:  r_state <= S_RD_LO;
                S_RD_LO:    r_state <= S_RD_HI;
                S_RD_HI:    r_state <= S_RD_TAIL;
                S_RD_TAIL:  r_state <= S_HDR_WAIT;
                S_HDR_WAIT: r_state <= S_DECIDE;
                S_DECIDE: begin
                    if (i_stat.type_ck) begin
                        r_state <= S_WALK;
                    end else begin
                        r_status <= i_stat.len_ok ? ST_LEN_OK : ST_LEN_BAD;
                        r_state  <= S_EMIT;
                    end
                end
                S_WALK: begin
                    if (i_stat.walk_last) begin
                        r_state <= S_WALK_WAIT;
                    end
                end
                S_WALK_WAIT: r_state <= S_CK_RES;
                S_CK_RES: begin
                    r_status <= i_stat.ck_ok ? ST_CK_OK : ST_CK_BAD;
                    r_state  <= S_EMIT;
                end
                S_EMIT: begin
                    if (i_stat.out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_accept_decodes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_in_valid) |=> (r_state == S_DECODE))
        else $error("accepted item was not decoded");

    a_frame_resyncs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && (r_status == ST_CK_OK || r_status == ST_LEN_OK
            || r_status == ST_CK_BAD || r_status == ST_LEN_BAD)) |-> (r_phase == PH_HEAD1))
        else $error("frame result while still inside a frame");

    a_decide_after_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DECIDE) |-> ($past(r_state) == S_HDR_WAIT))
        else $error("frame check entered before the header was read");
`endif

endmodule

// ----- hw/rtl/frame_parser_xor_checksum.sv -----
// Channel  Direction  Handshake                 Payload
// input    in         i_in_valid / o_in_stall   i_rx_byte
// result   out        o_out_valid / i_out_stall frame status, id, type, length, byte info
// config   in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// An ordinary byte passes through the decode and emit steps before the next acceptance.
// A frame-closing byte adds reads of the header and tail bytes, plus a checksum
// walk when the type calls for one (one buffer byte per cycle; a length above 255 counts as 0).
// After reset the 512-byte buffer is cleared one entry per cycle; no item is accepted
// until the clear is done. Configuration writes are always taken.
// A stalled result holds the block in its emit step until the result is taken.
module frame_parser_xor_checksum (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [7:0]                      i_rx_byte,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [fpx_pkg::STAT_W-1:0]      o_frame_status,
    output logic [7:0]                      o_frame_id,
    output logic [7:0]                      o_frame_type,
    output logic [fpx_pkg::LEN_W-1:0]       o_frame_length,
    output logic                            o_byte_stored,
    output logic [fpx_pkg::POS_W-1:0]       o_byte_position,
    output logic [7:0]                      o_byte_value,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [fpx_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [7:0]                      i_cfg_data
);
    import fpx_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    assign o_cfg_ready = 1'b1;

    fpx_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    fpx_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_rx_byte       (i_rx_byte),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_frame_status  (o_frame_status),
        .o_frame_id      (o_frame_id),
        .o_frame_type    (o_frame_type),
        .o_frame_length  (o_frame_length),
        .o_byte_stored   (o_byte_stored),
        .o_byte_position (o_byte_position),
        .o_byte_value    (o_byte_value)
    );

endmodule
